// File: src/v2dconv_pkg.sv
// Package for the valid KxK 2-D convolution block.
// Holds default sizes, field widths, register codes and shared structs.
// Used by every file in src.
package v2dconv_pkg;

  localparam int WIN_SIZE_DEF   = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int SAMPLE_W    = 16;
  localparam int COEFF_W     = 12;
  localparam int NUM_ROWS    = 5;
  localparam int ROW_W       = 60;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 60;
  localparam int WIDTH_REG_W = 11;
  localparam int WIDTH_RESET = 1024;

  localparam int PROD_W    = 28;
  localparam int ACC_W     = 34;
  localparam int FRAC_BITS = 10;
  localparam int CONV_W    = 24;
  localparam int OCOL_W    = 10;
  localparam int OROW_W    = 12;

  localparam int OFIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH = 3'd0,
    REG_COEFF_ROW_0 = 3'd1,
    REG_COEFF_ROW_1 = 3'd2,
    REG_COEFF_ROW_2 = 3'd3,
    REG_COEFF_ROW_3 = 3'd4,
    REG_COEFF_ROW_4 = 3'd5
  } cfg_reg_t;

  typedef logic [ROW_W-1:0] coeff_row_t;

  typedef struct packed {
    logic              valid;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
  } conv_meta_t;

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic [OCOL_W-1:0]        out_col;
    logic [OROW_W-1:0]        out_row;
  } conv_word_t;

endpackage

// File: src/v2dconv_if.sv
// Stream interfaces of the convolution block: sample input and result output.
// Depends on v2dconv_pkg for field widths.
interface v2dconv_in_if import v2dconv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       frame_start;

  modport source (output valid, sample, frame_start, input ready);
  modport sink (input valid, sample, frame_start, output ready);
endinterface

interface v2dconv_out_if import v2dconv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CONV_W-1:0] conv_value;
  logic [OCOL_W-1:0]        out_col;
  logic [OROW_W-1:0]        out_row;

  modport source (output valid, conv_value, out_col, out_row, input ready);
  modport sink (input valid, conv_value, out_col, out_row, output ready);
endinterface

// File: src/valid_2d_convolution.sv
// Top level of the valid KxK 2-D convolution: config registers, credit control.
// Depends on v2dconv_pkg, v2dconv_if, v2dconv_linebuf, v2dconv_mac, v2dconv_ofifo.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+----------------------------------
//   in_ch    | in  | valid/ready          | sample, frame_start
//   out_ch   | out | valid/ready          | conv_value, out_col, out_row
//   cfg_*    | in  | cfg_we, no back-off  | cfg_index, cfg_wdata
//
// One sample per clock, sustained while in_ch.ready is high.
// The line store has one read and one write port, used once per sample.
// An 8-word result queue absorbs output stalls; in_ch.ready drops only when
// queued plus in-flight results would exceed it.
// Synchronous reset; no clearing pass: the line store is undefined until written.
module valid_2d_convolution import v2dconv_pkg::*; #(
  parameter int WIN_SIZE   = WIN_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  v2dconv_in_if.sink            in_ch,
  v2dconv_out_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNTW = $clog2(OFIFO_DEPTH + 1);
  localparam int PW   = CNTW + 1;

  logic [WIDTH_REG_W-1:0] width_r;
  coeff_row_t             coeff_r [NUM_ROWS];

  logic                   accept, in_rdy;
  logic [WIN_SIZE-1:0][WIN_SIZE-1:0][SAMPLE_W-1:0] win;
  conv_meta_t             meta;
  logic [1:0]             lb_busy, mac_busy;
  logic                   push;
  conv_word_t             push_word;
  logic [CNTW-1:0]        fifo_count;
  logic [PW-1:0]          pending;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_REG_W'(WIDTH_RESET);
      for (int i = 0; i < NUM_ROWS; i++) begin
        coeff_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: width_r    <= cfg_wdata[WIDTH_REG_W-1:0];
        REG_COEFF_ROW_0: coeff_r[0] <= cfg_wdata[ROW_W-1:0];
        REG_COEFF_ROW_1: coeff_r[1] <= cfg_wdata[ROW_W-1:0];
        REG_COEFF_ROW_2: coeff_r[2] <= cfg_wdata[ROW_W-1:0];
        REG_COEFF_ROW_3: coeff_r[3] <= cfg_wdata[ROW_W-1:0];
        REG_COEFF_ROW_4: coeff_r[4] <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Credit check: every result in flight already has a queue slot.
  always_comb begin
    pending = PW'(fifo_count) + PW'(lb_busy[0]) + PW'(lb_busy[1])
            + PW'(mac_busy[0]) + PW'(mac_busy[1]);
    in_rdy  = pending < PW'(OFIFO_DEPTH);
  end

  assign in_ch.ready = in_rdy;
  assign accept      = in_ch.valid & in_rdy;

  v2dconv_linebuf #(
    .WIN_SIZE    (WIN_SIZE),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_linebuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .sample      (in_ch.sample),
    .frame_start (in_ch.frame_start),
    .width_r     (width_r),
    .win         (win),
    .meta        (meta),
    .busy        (lb_busy)
  );

  v2dconv_mac #(
    .WIN_SIZE  (WIN_SIZE)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win),
    .meta      (meta),
    .coeff     (coeff_r),
    .push      (push),
    .push_word (push_word),
    .busy      (mac_busy)
  );

  v2dconv_ofifo #(
    .DEPTH (OFIFO_DEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .out_ch    (out_ch),
    .count     (fifo_count)
  );

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((fifo_count == '0) && (lb_busy == '0) && (mac_busy == '0)) |=> !out_ch.valid)
    else $error("result word appeared with nothing in flight");

endmodule

// File: src/v2dconv_linebuf.sv
// Raster position counters, line-store memory and the KxK sample window.
// Depends on v2dconv_pkg.
module v2dconv_linebuf import v2dconv_pkg::*; #(
  parameter int WIN_SIZE   = WIN_SIZE_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              accept,
  input  logic signed [SAMPLE_W-1:0]                        sample,
  input  logic                                              frame_start,
  input  logic [WIDTH_REG_W-1:0]                            width_r,
  output logic [WIN_SIZE-1:0][WIN_SIZE-1:0][SAMPLE_W-1:0]   win,
  output conv_meta_t                                        meta,
  output logic [1:0]                                        busy
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int KM1   = WIN_SIZE - 1;
  localparam int LINES = (WIN_SIZE > 1) ? WIN_SIZE - 1 : 1;
  localparam int MW    = LINES * SAMPLE_W;
  localparam int EW    = 14;

  logic [CW-1:0] col_r, col_base, col_cur, col_nxt, col_off;
  logic [RW-1:0] row_r, row_cur, row_nxt, row_off;
  logic [EW-1:0] w_ext, eff;
  logic          last, produce;

  logic                       s1_valid_r, s1_produce_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [CW-1:0]              s1_col_r;
  logic [OCOL_W-1:0]          s1_ocol_r;
  logic [OROW_W-1:0]          s1_orow_r;

  logic [MW-1:0] line_rd;
  logic [WIN_SIZE-1:0][WIN_SIZE-1:0][SAMPLE_W-1:0] win_r;
  conv_meta_t m2_r;

  // Position of the incoming sample; width 0 acts as 1, oversize as the store size.
  always_comb begin
    w_ext    = EW'(width_r);
    eff      = (w_ext == '0) ? EW'(1) :
               (w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext;
    col_base = frame_start ? '0 : col_r;
    row_cur  = frame_start ? '0 : row_r;
    col_cur  = (EW'(col_base) >= eff) ? '0 : col_base;
    last     = (EW'(col_cur) + EW'(1)) >= eff;
    produce  = (EW'(col_cur) >= EW'(KM1)) && (row_cur >= RW'(KM1));
    col_nxt  = last ? '0 : col_cur + CW'(1);
    row_nxt  = (last && (row_cur != RW'(MAX_HEIGHT - 1))) ? row_cur + RW'(1) : row_cur;
    col_off  = col_cur - CW'(KM1);
    row_off  = row_cur - RW'(KM1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      s1_valid_r   <= 1'b0;
      s1_produce_r <= 1'b0;
    end else begin
      s1_valid_r   <= accept;
      s1_produce_r <= accept & produce;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= sample;
      s1_col_r    <= col_cur;
      s1_ocol_r   <= OCOL_W'(col_off);
      s1_orow_r   <= OROW_W'(row_off);
    end
  end

  generate
    if (WIN_SIZE > 1) begin : g_store
      logic [MW-1:0] mem [MAX_WIDTH];
      logic [MW-1:0] rd_r;
      logic [MW-1:0] wr_word;

      // Each word holds one column of the stored lines, oldest line in the low lane.
      always_comb begin
        for (int r = 0; r < LINES - 1; r++) begin
          wr_word[r*SAMPLE_W +: SAMPLE_W] = rd_r[(r+1)*SAMPLE_W +: SAMPLE_W];
        end
        wr_word[(LINES-1)*SAMPLE_W +: SAMPLE_W] = s1_sample_r;
      end

      always_ff @(posedge clk) begin
        if (s1_valid_r) begin
          mem[s1_col_r] <= wr_word;
        end
      end

      // Forward the word being written when the next sample hits the same column.
      always_ff @(posedge clk) begin
        if (accept) begin
          if (s1_valid_r && (s1_col_r == col_cur)) begin
            rd_r <= wr_word;
          end else begin
            rd_r <= mem[col_cur];
          end
        end
      end

      assign line_rd = rd_r;
    end else begin : g_nostore
      assign line_rd = '0;
    end
  endgenerate

  // Shift the window left and load the new column on the right.
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int r = 0; r < WIN_SIZE; r++) begin
        for (int c = 0; c < WIN_SIZE - 1; c++) begin
          win_r[r][c] <= win_r[r][c+1];
        end
      end
      for (int r = 0; r < WIN_SIZE - 1; r++) begin
        win_r[r][WIN_SIZE-1] <= line_rd[r*SAMPLE_W +: SAMPLE_W];
      end
      win_r[WIN_SIZE-1][WIN_SIZE-1] <= s1_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r <= '0;
    end else begin
      m2_r.valid <= s1_produce_r;
      m2_r.col   <= s1_ocol_r;
      m2_r.row   <= s1_orow_r;
    end
  end

  assign win  = win_r;
  assign meta = m2_r;
  assign busy = {m2_r.valid, s1_produce_r};

  a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && frame_start && (eff > EW'(1))) |=> (col_r == CW'(1)))
    else $error("column count not restarted by frame start");

  a_row_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (row_r >= $past(row_cur)))
    else $error("row count moved backward");

endmodule

// File: src/v2dconv_mac.sv
// Multiply-accumulate pipeline: window times kernel, row sums, total and shift.
// Depends on v2dconv_pkg.
module v2dconv_mac import v2dconv_pkg::*; #(
  parameter int WIN_SIZE = WIN_SIZE_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic [WIN_SIZE-1:0][WIN_SIZE-1:0][SAMPLE_W-1:0]   win,
  input  conv_meta_t                                        meta,
  input  coeff_row_t                                        coeff [NUM_ROWS],
  output logic                                              push,
  output conv_word_t                                        push_word,
  output logic [1:0]                                        busy
);

  localparam int RSUM_W = PROD_W + 3;

  logic signed [PROD_W-1:0] prod_r [WIN_SIZE][WIN_SIZE];
  logic signed [RSUM_W-1:0] rsum_nxt [WIN_SIZE];
  logic signed [RSUM_W-1:0] rsum_r [WIN_SIZE];
  logic signed [ACC_W-1:0]  acc;
  conv_meta_t               m3_r, m4_r;

  always_ff @(posedge clk) begin
    for (int r = 0; r < WIN_SIZE; r++) begin
      for (int c = 0; c < WIN_SIZE; c++) begin
        prod_r[r][c] <= $signed(coeff[r][c*COEFF_W +: COEFF_W]) * $signed(win[r][c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < WIN_SIZE; r++) begin
      rsum_nxt[r] = '0;
      for (int c = 0; c < WIN_SIZE; c++) begin
        rsum_nxt[r] = rsum_nxt[r] + RSUM_W'(prod_r[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    rsum_r <= rsum_nxt;
  end

  // Floor shift: drop the fraction bits of the window sum.
  always_comb begin
    acc = '0;
    for (int r = 0; r < WIN_SIZE; r++) begin
      acc = acc + ACC_W'(rsum_r[r]);
    end
    push_word.conv_value = acc[FRAC_BITS +: CONV_W];
    push_word.out_col    = m4_r.col;
    push_word.out_row    = m4_r.row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_r <= '0;
      m4_r <= '0;
    end else begin
      m3_r <= meta;
      m4_r <= m3_r;
    end
  end

  assign push = m4_r.valid;
  assign busy = {m4_r.valid, m3_r.valid};

endmodule

// File: src/v2dconv_ofifo.sv
// Output queue of result words; decouples the result channel from the pipeline.
// Depends on v2dconv_pkg and v2dconv_out_if.
module v2dconv_ofifo import v2dconv_pkg::*; #(
  parameter int DEPTH = OFIFO_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  conv_word_t               push_word,
  v2dconv_out_if.source            out_ch,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  conv_word_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            pop;
  conv_word_t      head;

  assign pop  = out_ch.valid & out_ch.ready;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNTW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNTW'(1);
      end
    end
  end

  assign out_ch.valid      = (count_r != '0);
  assign out_ch.conv_value = head.conv_value;
  assign out_ch.out_col    = head.out_col;
  assign out_ch.out_row    = head.out_row;
  assign count             = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((count_r < CNTW'(DEPTH)) || pop))
    else $error("result queue overflow");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNTW'(1)))
    else $error("result queue count lost a pop");

endmodule

// File: test/tb_valid_2d_convolution.sv
// Self-checking testbench of valid_2d_convolution: streams sample frames, predicts
// every windowed sum in step with the accepted samples and checks the result stream.
// Depends on v2dconv_pkg, v2dconv_if and the block itself from src.
`timescale 1ns / 100ps

module tb_valid_2d_convolution;
  import v2dconv_pkg::*;

  localparam int KS             = WIN_SIZE_DEF;
  localparam int LINES          = KS - 1;
  localparam int MAX_W          = MAX_WIDTH_DEF;
  localparam int MAX_H          = MAX_HEIGHT_DEF;
  localparam int SETTLE_CYCLES  = 16;
  localparam int CYCLE_LIMIT    = 100000;
  localparam int RANDOM_ITEMS   = 850;
  localparam int RANDOM_RESULTS = 50;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  v2dconv_in_if  in_ch();
  v2dconv_out_if out_ch();

  valid_2d_convolution i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: registers, line stores, window and position.
  logic [WIDTH_REG_W-1:0]     width_reg = WIDTH_REG_W'(WIDTH_RESET);
  coeff_row_t                 coeff_reg [NUM_ROWS];
  logic signed [SAMPLE_W-1:0] line_mem [LINES][MAX_W];
  logic signed [SAMPLE_W-1:0] win [KS][KS];
  int unsigned                col_pos = 0;
  int unsigned                row_pos = 0;

  conv_word_t conv_expected [$];
  pixel_t     pixel_queue [$];
  int         conv_total     = 0;
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_idle_pct  = 0;
  logic       in_fire        = 1'b0;

  initial begin
    for (int r = 0; r < NUM_ROWS; r++) coeff_reg[r] = '0;
    for (int r = 0; r < KS; r++)
      for (int c = 0; c < KS; c++) win[r][c] = '0;
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < MAX_W; c++) line_mem[r][c] = '0;
  end

  task automatic convolve_sample(input logic signed [SAMPLE_W-1:0] s, input logic fs);
    int unsigned                w;
    longint                     acc;
    logic signed [COEFF_W-1:0]  k;
    conv_word_t                 res;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    // shift the window left, pull the new column from the line stores
    for (int r = 0; r < KS; r++)
      for (int c = 0; c < KS - 1; c++) win[r][c] = win[r][c+1];
    for (int r = 0; r < LINES; r++) win[r][KS-1] = line_mem[r][col_pos];
    win[KS-1][KS-1] = s;
    for (int r = 0; r < LINES - 1; r++) line_mem[r][col_pos] = line_mem[r+1][col_pos];
    line_mem[LINES-1][col_pos] = s;
    if (row_pos >= KS - 1 && col_pos >= KS - 1) begin
      acc = 0;
      for (int r = 0; r < KS; r++)
        for (int c = 0; c < KS; c++) begin
          k = coeff_reg[r][c*COEFF_W +: COEFF_W];
          acc += longint'(k) * longint'(win[r][c]);
        end
      // floor shift: drop the fraction bits of the exact sum
      res.conv_value = acc[CONV_W+FRAC_BITS-1:FRAC_BITS];
      res.out_col    = OCOL_W'(col_pos - (KS - 1));
      res.out_row    = OROW_W'(row_pos - (KS - 1));
      conv_expected.push_back(res);
      conv_total++;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < MAX_H - 1) row_pos++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_W-1:0];
    else coeff_reg[idx - REG_COEFF_ROW_0] = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [SAMPLE_W-1:0] s, input logic fs);
    pixel_t px;
    px.sample      = s;
    px.frame_start = fs;
    pixel_queue.push_back(px);
  endtask

  // Hold until every word is sent and every result is back, then let the pipe settle.
  task automatic drain_block();
    while (pixel_queue.size() != 0 || in_ch.valid || conv_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pacing(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(7))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic coeff_row_t pick_coeff_row();
    coeff_row_t          row;
    logic [COEFF_W-1:0]  k;
    row = '0;
    for (int c = 0; c < NUM_ROWS; c++) begin
      case ($urandom_range(5))
        0:       k = 12'h800;
        1:       k = 12'h7FF;
        2:       k = 12'h000;
        default: k = COEFF_W'($urandom);
      endcase
      row[c*COEFF_W +: COEFF_W] = k;
    end
    return row;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: timeout after %0d cycles, %0d results outstanding",
             cycle_count, conv_expected.size());
    $display("** valid_2d_convolution: FAILED **");
    $finish;
  end

  // Sender: present the next word at the falling edge once the last one is taken.
  always @(negedge clk) begin : drive_pixels
    pixel_t px;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pixel_queue.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.sample      <= px.sample;
        in_ch.frame_start <= px.frame_start;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : watch_ports
    conv_word_t want;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) convolve_sample(in_ch.sample, in_ch.frame_start);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (conv_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d col %0d row %0d",
                                  out_ch.conv_value, out_ch.out_col, out_ch.out_row));
      end else begin
        want = conv_expected.pop_front();
        if (out_ch.conv_value !== want.conv_value)
          report_mismatch($sformatf("conv_value %0d, want %0d (col %0d row %0d)",
                                    out_ch.conv_value, want.conv_value,
                                    want.out_col, want.out_row));
        if (out_ch.out_col !== want.out_col)
          report_mismatch($sformatf("out_col %0d, want %0d", out_ch.out_col, want.out_col));
        if (out_ch.out_row !== want.out_row)
          report_mismatch($sformatf("out_row %0d, want %0d", out_ch.out_row, want.out_row));
      end
    end
  end

  initial begin : stimulus
    int w;
    int weff;
    int n;
    int base;
    int random_items;
    logic [SAMPLE_W-1:0] s;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_IMAGE_WIDTH;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Largest positive sum: most negative coefficients times most negative samples.
    set_pacing(13, 48);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(KS));
    write_reg(REG_COEFF_ROW_0, {5{12'h800}});
    write_reg(REG_COEFF_ROW_1, {5{12'h800}});
    write_reg(REG_COEFF_ROW_2, {5{12'h800}});
    write_reg(REG_COEFF_ROW_3, {5{12'hFFF}});
    write_reg(REG_COEFF_ROW_4, {5{12'hFFF}});
    for (int i = 0; i < KS * KS; i++) queue_pixel(16'h8000, i == 0);
    drain_block();

    // Mixed extremes over a wider line.
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_COEFF_ROW_0, {5{12'h7FF}});
    write_reg(REG_COEFF_ROW_1, {5{12'h800}});
    write_reg(REG_COEFF_ROW_2, {12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'h001});
    for (int i = 0; i < 15; i++) begin
      case (i % 5)
        0:       s = 16'h8000;
        1:       s = 16'h7FFF;
        2:       s = 16'h0000;
        3:       s = 16'hFFFF;
        default: s = 16'h0001;
      endcase
      queue_pixel(s, i == 0);
    end
    drain_block();

    // Narrow and odd widths: zero acts as one, nothing comes out.
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
    for (int i = 0; i < 8; i++) queue_pixel(pick_sample(), i == 0);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
    for (int i = 0; i < 8; i++) queue_pixel(pick_sample(), i == 0);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    for (int i = 0; i < 12; i++) queue_pixel(pick_sample(), i == 0);
    drain_block();
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_W));
    for (int i = 0; i < 20; i++) queue_pixel(pick_sample(), i == 0);
    drain_block();

    // Width above the maximum clamps to full lines.
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2047));
    for (int i = 0; i < 24; i++) queue_pixel(pick_sample(), i == 0);
    drain_block();

    // Random frames, each under a fresh setting.
    random_items = 0;
    base = conv_total;
    while (random_items < RANDOM_ITEMS || conv_total - base < RANDOM_RESULTS) begin
      if (random_items < RANDOM_ITEMS / 3) set_pacing(13, 48);
      else if (random_items < 2 * RANDOM_ITEMS / 3) set_pacing(48, 13);
      else set_pacing(0, 0);
      case ($urandom_range(15))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(25, 64);
        default: w = $urandom_range(KS, 12);
      endcase
      weff = (w == 0) ? 1 : w;
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
      for (int r = 0; r < NUM_ROWS; r++)
        write_reg(cfg_reg_t'(REG_COEFF_ROW_0 + r), pick_coeff_row());
      n = weff * $urandom_range(3, 7) + $urandom_range(0, weff);
      // mostly whole frames, with a stray frame start now and then
      for (int i = 0; i < n; i++) queue_pixel(pick_sample(), i == 0 || $urandom_range(63) == 0);
      random_items += n;
      drain_block();
    end

    if (mismatch_count == 0) begin
      $display("** valid_2d_convolution: PASSED **");
    end else begin
      $display("** valid_2d_convolution: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/v2dconv_pkg.sv
src/v2dconv_if.sv
src/v2dconv_linebuf.sv
src/v2dconv_mac.sv
src/v2dconv_ofifo.sv
src/valid_2d_convolution.sv
test/tb_valid_2d_convolution.sv
